// ===== rtl/mexp_pkg.sv =====
// Shared constants for the modular exponentiation core: register indexes and state codes.
`timescale 1ns / 1ps

package mexp_pkg;

	// Register indexes on the configuration write port.
	localparam int unsigned REG_INDEX_WIDTH = 1;
	localparam logic [REG_INDEX_WIDTH-1:0] REG_MODULUS  = 1'b0;
	localparam logic [REG_INDEX_WIDTH-1:0] REG_EXPONENT = 1'b1;

	// Sequencer state vector.
	localparam int unsigned STATE_WIDTH = 3;
	typedef logic [STATE_WIDTH-1:0] state_t;

	localparam state_t ST_IDLE   = 3'd0;
	localparam state_t ST_REDUCE = 3'd1;
	localparam state_t ST_EXP    = 3'd2;
	localparam state_t ST_MULA   = 3'd3;
	localparam state_t ST_MULS   = 3'd4;
	localparam state_t ST_FINISH = 3'd5;

endpackage

// ===== rtl/modular_exponentiation_core.sv =====
// Modular exponentiation core: base ^ exponent mod modulus by bit-serial square-and-multiply.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake              Payload
//  in        input      in_valid / in_stall    base   [MOD_WIDTH-1:0]
//  out       output     out_valid / out_stall  result [MOD_WIDTH-1:0]
//  config    input      wr_en                  wr_index, wr_data [MOD_WIDTH-1:0]
//
//  A word first has its base reduced bit by bit, then per exponent bit up to the highest
//  set one a test step, a multiply where the bit is set and a squaring, each a run of
//  add-and-double steps on the single shared multiply unit. A zero modulus skips all
//  arithmetic, and a zero exponent skips the multiplies and squarings.
//  Reset (arst_n low) returns the modulus to 2 and the exponent to 1 and empties the core.
//  A finished result waits in the output register while the next word is accepted.

module modular_exponentiation_core
	import mexp_pkg::*;
#(
	parameter int unsigned MOD_WIDTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [MOD_WIDTH-1:0]       base,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [MOD_WIDTH-1:0]       result,
	input  logic                       wr_en,
	input  logic [REG_INDEX_WIDTH-1:0] wr_index,
	input  logic [MOD_WIDTH-1:0]       wr_data
);

	localparam int unsigned CNT_WIDTH = (MOD_WIDTH > 1) ? $clog2(MOD_WIDTH) : 1;
	localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(MOD_WIDTH - 1);
	localparam logic [MOD_WIDTH-1:0] MOD_ZERO = '0;
	localparam logic [MOD_WIDTH-1:0] MOD_ONE  = MOD_WIDTH'(1);

	state_t                state_q;
	logic [MOD_WIDTH-1:0]  modulus_q;
	logic [MOD_WIDTH-1:0]  exponent_q;
	logic [MOD_WIDTH-1:0]  base_sh_q;
	logic [CNT_WIDTH-1:0]  cnt_q;
	logic [MOD_WIDTH-1:0]  rem_q;
	logic [MOD_WIDTH-1:0]  acc_q;
	logic [MOD_WIDTH-1:0]  sq_q;
	logic [MOD_WIDTH-1:0]  exp_sh_q;
	logic [MOD_WIDTH-1:0]  madd_q;
	logic [MOD_WIDTH-1:0]  mb_q;
	logic [MOD_WIDTH-1:0]  macc_q;
	logic                  out_valid_q;
	logic [MOD_WIDTH-1:0]  result_q;

	logic [MOD_WIDTH:0]    rem_trial;
	logic [MOD_WIDTH-1:0]  rem_next;
	logic [MOD_WIDTH:0]    acc_sum;
	logic [MOD_WIDTH-1:0]  acc_sum_red;
	logic [MOD_WIDTH:0]    dbl_sum;
	logic [MOD_WIDTH-1:0]  dbl_sum_red;
	logic                  in_accept;
	logic                  out_free;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= MOD_WIDTH'(2);
			exponent_q <= MOD_ONE;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MODULUS:  modulus_q  <= wr_data;
				REG_EXPONENT: exponent_q <= wr_data;
				default:      ;
			endcase
		end
	end

	// One restoring step of the base reduction: bring in one base bit, subtract if it fits.
	always_comb begin
		rem_trial = {rem_q, base_sh_q[MOD_WIDTH-1]};
		if (rem_trial >= {1'b0, modulus_q}) begin
			rem_next = MOD_WIDTH'(rem_trial - {1'b0, modulus_q});
		end else begin
			rem_next = rem_trial[MOD_WIDTH-1:0];
		end
	end

	// One add-and-double step of the modular multiply; both sums stay below the modulus.
	always_comb begin
		acc_sum = {1'b0, macc_q} + {1'b0, madd_q};
		if (acc_sum >= {1'b0, modulus_q}) begin
			acc_sum_red = MOD_WIDTH'(acc_sum - {1'b0, modulus_q});
		end else begin
			acc_sum_red = acc_sum[MOD_WIDTH-1:0];
		end
		dbl_sum = {madd_q, 1'b0};
		if (dbl_sum >= {1'b0, modulus_q}) begin
			dbl_sum_red = MOD_WIDTH'(dbl_sum - {1'b0, modulus_q});
		end else begin
			dbl_sum_red = dbl_sum[MOD_WIDTH-1:0];
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= (modulus_q == MOD_ZERO) ? ST_FINISH : ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					if (cnt_q == '0) begin
						state_q <= ST_EXP;
					end
				end
				ST_EXP: begin
					priority if (exp_sh_q == MOD_ZERO) begin
						state_q <= ST_FINISH;
					end else if (exp_sh_q[0]) begin
						state_q <= ST_MULA;
					end else begin
						state_q <= ST_MULS;
					end
				end
				ST_MULA: begin
					if (mb_q == MOD_ZERO) begin
						state_q <= ST_MULS;
					end
				end
				ST_MULS: begin
					if (mb_q == MOD_ZERO) begin
						state_q <= ST_EXP;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output word valid: set when a finished result moves in, cleared when it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FINISH) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Datapath shift registers and the shared multiply unit.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				base_sh_q <= base;
				cnt_q     <= CNT_LAST;
				rem_q     <= MOD_ZERO;
				acc_q     <= MOD_ZERO;
				exp_sh_q  <= exponent_q;
			end
			ST_REDUCE: begin
				rem_q     <= rem_next;
				base_sh_q <= {base_sh_q[MOD_WIDTH-2:0], 1'b0};
				cnt_q     <= cnt_q - CNT_WIDTH'(1);
				if (cnt_q == '0) begin
					sq_q  <= rem_next;
					acc_q <= (modulus_q == MOD_ONE) ? MOD_ZERO : MOD_ONE;
				end
			end
			ST_EXP: begin
				macc_q <= MOD_ZERO;
				mb_q   <= sq_q;
				madd_q <= exp_sh_q[0] ? acc_q : sq_q;
			end
			ST_MULA, ST_MULS: begin
				if (mb_q == MOD_ZERO) begin
					if (state_q == ST_MULA) begin
						acc_q  <= macc_q;
						macc_q <= MOD_ZERO;
						mb_q   <= sq_q;
						madd_q <= sq_q;
					end else begin
						sq_q     <= macc_q;
						exp_sh_q <= {1'b0, exp_sh_q[MOD_WIDTH-1:1]};
					end
				end else begin
					if (mb_q[0]) begin
						macc_q <= acc_sum_red;
					end
					madd_q <= dbl_sum_red;
					mb_q   <= {1'b0, mb_q[MOD_WIDTH-1:1]};
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					result_q <= acc_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

	// The partial remainder never reaches the modulus while the base is reduced.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REDUCE) |-> (rem_q < modulus_q))
		else $error("base reduction remainder not below modulus");

	// Multiply operands stay reduced throughout the add-and-double steps.
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_MULA) || (state_q == ST_MULS)) |->
			((macc_q < modulus_q) && (madd_q < modulus_q)))
		else $error("multiply operand not below modulus");

	// A fresh result is reduced, or zero when the modulus is zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ((result_q < modulus_q) || (modulus_q == MOD_ZERO)))
		else $error("result not below modulus");

	// A zero modulus skips all arithmetic.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && (modulus_q == MOD_ZERO)) |=> (state_q == ST_FINISH))
		else $error("zero modulus did not bypass the arithmetic");

endmodule

// ===== test/tb_modular_exponentiation_core.sv =====
// Self-checking testbench for the modular exponentiation core with random stalls on both sides.
`timescale 1ns / 1ps

module tb_modular_exponentiation_core
	import mexp_pkg::*;
();

	localparam int unsigned W = 16;
	localparam int unsigned STALL_PERCENT = 31;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned DRAIN_CYCLES = 700;
	localparam int unsigned REPORT_LIMIT = 10;
	localparam int unsigned RANDOM_BATCHES = 12;
	localparam int unsigned WORDS_PER_BATCH = 80;
	localparam int unsigned CALM_BATCH = 4;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [W-1:0] base = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [W-1:0] result;
	logic wr_en = 1'b0;
	logic [REG_INDEX_WIDTH-1:0] wr_index = REG_MODULUS;
	logic [W-1:0] wr_data = '0;

	// Bases waiting to be sent, and powers still owed by the core.
	logic [W-1:0] pending_bases[$];
	logic [W-1:0] owed_powers[$];

	// Shadow copy of the key registers, as the core holds them.
	logic [W-1:0] key_modulus = 16'd2;
	logic [W-1:0] key_exponent = 16'd1;

	bit calm = 1'b0;
	bit base_taken = 1'b0;
	int unsigned faults = 0;
	int unsigned reported = 0;
	int unsigned words_out = 0;
	int unsigned quiet_cycles = 0;

	modular_exponentiation_core #(
		.MOD_WIDTH(W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.base(base),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result(result),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// (a + b) mod m for a and b already below m.
	function automatic logic [W-1:0] residue_sum(input logic [W-1:0] a, input logic [W-1:0] b,
			input logic [W-1:0] m);
		logic [W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, m})
			s = s - {1'b0, m};
		return s[W-1:0];
	endfunction

	// (a * b) mod m by add-and-double over the bits of b.
	function automatic logic [W-1:0] residue_product(input logic [W-1:0] a, input logic [W-1:0] b,
			input logic [W-1:0] m);
		logic [W-1:0] acc;
		logic [W-1:0] dbl;
		acc = '0;
		dbl = a;
		for (int i = 0; i < W; i++) begin
			if (b[i])
				acc = residue_sum(acc, dbl, m);
			dbl = residue_sum(dbl, dbl, m);
		end
		return acc;
	endfunction

	// Expected power: base ^ exponent mod modulus, with a zero modulus giving zero.
	function automatic logic [W-1:0] predict_power(input logic [W-1:0] b, input logic [W-1:0] e,
			input logic [W-1:0] m);
		logic [W-1:0] acc;
		logic [W-1:0] sq;
		if (m == '0)
			return '0;
		acc = (m == 16'd1) ? '0 : 16'd1;
		sq = b % m;
		for (int i = 0; i < W; i++) begin
			if (e[i])
				acc = residue_product(acc, sq, m);
			sq = residue_product(sq, sq, m);
		end
		return acc;
	endfunction

	// Input driver: hold a stalled word, otherwise offer the next one or idle.
	always @(negedge clk) begin
		if (!(in_valid && !base_taken)) begin
			base_taken = 1'b0;
			if (pending_bases.size() != 0 && (calm || $urandom_range(99) >= STALL_PERCENT)) begin
				in_valid <= 1'b1;
				base <= pending_bases[0];
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= calm ? 1'b0 : ($urandom_range(99) < STALL_PERCENT);
	end

	// Monitor: track key writes, predict on each accepted word and check each result word.
	always @(posedge clk) begin
		if (arst_n) begin
			if (wr_en) begin
				case (wr_index)
					REG_MODULUS: begin
						key_modulus = wr_data;
					end
					REG_EXPONENT: begin
						key_exponent = wr_data;
					end
					default: begin
					end
				endcase
			end
			if (in_valid && !in_stall) begin
				owed_powers.push_back(predict_power(base, key_exponent, key_modulus));
				void'(pending_bases.pop_front());
				base_taken = 1'b1;
			end
			if (out_valid && !out_stall) begin
				if (owed_powers.size() == 0) begin
					faults++;
					if (reported < REPORT_LIMIT) begin
						reported++;
						$display("word %0d: result %0d arrived with none expected", words_out,
							result);
					end
				end else if (result !== owed_powers[0]) begin
					faults++;
					if (reported < REPORT_LIMIT) begin
						reported++;
						$display("word %0d: expected result %0d, got %0d", words_out,
							owed_powers[0], result);
					end
					void'(owed_powers.pop_front());
				end else begin
					void'(owed_powers.pop_front());
				end
				words_out++;
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	// Watchdog: a core that stops moving words ends the run.
	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("tb_modular_exponentiation_core: errors");
		$finish;
	end

	// Write one key register through the configuration port.
	task automatic load_register(input logic [REG_INDEX_WIDTH-1:0] idx, input logic [W-1:0] value);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// Wait until every queued word has gone in and every result has come back.
	task automatic settle();
		while (pending_bases.size() != 0 || owed_powers.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic load_key(input logic [W-1:0] m, input logic [W-1:0] e);
		settle();
		load_register(REG_MODULUS, m);
		load_register(REG_EXPONENT, e);
	endtask

	initial begin
		logic [W-1:0] m;
		logic [W-1:0] e;
		int unsigned pick;

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Reset key: modulus two, exponent one.
		pending_bases = '{16'd0, 16'd1, 16'hFFFF, 16'h8000};

		// Widest key, with extreme and alternating bases.
		load_key(16'hFFFF, 16'hFFFF);
		pending_bases = '{16'd0, 16'd1, 16'hFFFE, 16'hFFFF, 16'h5555, 16'hAAAA};

		// Exponent zero gives one whatever the base.
		load_key(16'd3233, 16'd0);
		pending_bases = '{16'd65, 16'hFFFF, 16'd0};

		// Exponent one with bases not below the modulus.
		load_key(16'd3233, 16'd1);
		pending_bases = '{16'd5000, 16'hFFFF, 16'd3233};

		// Modulus one sends every result to zero.
		load_key(16'd1, 16'd17);
		pending_bases = '{16'd123, 16'hFFFF};

		// Modulus zero: no arithmetic, zero out.
		load_key(16'd0, 16'd5);
		pending_bases = '{16'd7, 16'hFFFF};

		// A small key pair: encrypt then decrypt.
		load_key(16'd3233, 16'd17);
		pending_bases = '{16'd65, 16'd2790};
		load_key(16'd3233, 16'd2753);
		pending_bases = '{16'd2790, 16'd3232};

		// Random keys and bases; one batch runs with no stalls at all.
		for (int unsigned batch = 0; batch < RANDOM_BATCHES; batch++) begin
			pick = $urandom_range(99);
			if (pick < 5)
				m = 16'd0;
			else if (pick < 10)
				m = 16'd1;
			else if (pick < 18)
				m = 16'd2;
			else if (pick < 26)
				m = 16'hFFFF;
			else if (pick < 40)
				m = W'($urandom_range(255, 2));
			else
				m = W'($urandom_range(65535, 2));
			pick = $urandom_range(99);
			if (pick < 8)
				e = 16'd0;
			else if (pick < 16)
				e = 16'd1;
			else if (pick < 26)
				e = 16'hFFFF;
			else if (pick < 50)
				e = W'($urandom_range(255, 2));
			else
				e = W'($urandom());
			load_key(m, e);
			calm = (batch == CALM_BATCH);
			for (int unsigned k = 0; k < WORDS_PER_BATCH; k++) begin
				if (m > 16'd1 && $urandom_range(99) < 30)
					pending_bases.push_back(W'($urandom_range(m - 1, 0)));
				else
					pending_bases.push_back(W'($urandom()));
			end
			settle();
			calm = 1'b0;
		end

		// Let any stray result show up before the verdict.
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		faults += owed_powers.size();
		if (faults == 0)
			$display("tb_modular_exponentiation_core: clean");
		else
			$display("tb_modular_exponentiation_core: errors");
		$finish;
	end

endmodule
